FILE: src/bps_pkg.sv
// Shared types, constants and the built-in step table of the buzzer pattern sequencer.
`default_nettype none

package bps_pkg;

    localparam logic [3:0] PATTERN_COUNT = 4'd12;

    typedef enum logic [1:0] {
        STEP_END   = 2'd0,
        STEP_TONE  = 2'd1,
        STEP_QUIET = 2'd2
    } step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        logic [12:0] hz;
        logic [11:0] ms;
    } step_t;

    typedef struct packed {
        logic       command;
        logic [3:0] sound_select;
    } req_t;

    typedef struct packed {
        logic        tone_on;
        logic [12:0] tone_freq;
        logic        playing;
    } rsp_t;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam step_t END_STEP = '{kind: STEP_END, hz: 13'd0, ms: 12'd0};

    function automatic step_t tone(input logic [12:0] hz, input logic [11:0] ms);
        step_t s;
        s.kind = STEP_TONE;
        s.hz   = hz;
        s.ms   = ms;
        return s;
    endfunction

    function automatic step_t quiet(input logic [11:0] ms);
        step_t s;
        s.kind = STEP_QUIET;
        s.hz   = 13'd0;
        s.ms   = ms;
        return s;
    endfunction

    // Step table, one row per pattern; unused slots hold the end step.
    function automatic step_t table_step(input logic [3:0] pat, input logic [5:0] slot);
        step_t s;
        logic  odd;
        s   = END_STEP;
        odd = slot[0];
        unique case (pat)
            4'd0:
                if (slot < 6'd2) s = odd ? quiet(12'd100) : tone(13'd4200, 12'd100);
            4'd1:
                if (slot < 6'd2) s = odd ? quiet(12'd20) : tone(13'd4200, 12'd20);
            4'd2:
                if (slot < 6'd4) s = odd ? quiet(12'd200) : tone(13'd4200, 12'd50);
            4'd3:
                if (slot < 6'd6) s = odd ? quiet(12'd2000) : tone(13'd4200, 12'd200);
            4'd4:
                if (slot < 6'd4) s = odd ? quiet(12'd200) : tone(13'd4200, 12'd100);
            4'd5:
                if (slot < 6'd4) s = odd ? quiet(12'd200) : tone(13'd4200, 12'd500);
            4'd6:
                if (slot < 6'd18)
                begin
                    if (odd)
                        s = quiet((slot == 6'd17) ? 12'd4000 : 12'd200);
                    else
                        s = tone(13'd4200,
                                 (slot >= 6'd6 && slot < 6'd12) ? 12'd800 : 12'd150);
                end
            4'd7:
                if (slot < 6'd4) s = odd ? quiet(12'd800) : tone(13'd4200, 12'd200);
            4'd8:
                if (slot < 6'd4) s = odd ? quiet(12'd100) : tone(13'd4200, 12'd100);
            4'd9:
                unique case (slot)
                    6'd0:    s = tone(13'd4200, 12'd250);
                    6'd1:    s = quiet(12'd250);
                    6'd2:    s = tone(13'd3800, 12'd250);
                    6'd3:    s = quiet(12'd3250);
                    default: s = END_STEP;
                endcase
            4'd10:
                unique case (slot)
                    6'd0:    s = tone(13'd4200, 12'd500);
                    6'd1:    s = quiet(12'd250);
                    6'd2:    s = tone(13'd4600, 12'd250);
                    6'd3:    s = quiet(12'd2000);
                    default: s = END_STEP;
                endcase
            4'd11:
                unique case (slot)
                    6'd0:    s = tone(13'd3800, 12'd500);
                    6'd1:    s = tone(13'd4200, 12'd500);
                    6'd2:    s = tone(13'd4600, 12'd500);
                    6'd3:    s = tone(13'd5000, 12'd500);
                    6'd4:    s = quiet(12'd100);
                    default: s = END_STEP;
                endcase
            default:
                s = END_STEP;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: src/bps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/bps_loader.sv
// Copies the constant step table into the step RAM once after reset.
`default_nettype none

module bps_loader #(
    parameter int STEP_SLOTS = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    output logic                                        we,
    output logic [$clog2(STEP_SLOTS)+3:0]               waddr,
    output bps_pkg::step_t                              wdata,
    output logic                                        loaded
);

    localparam int SLOT_W = $clog2(STEP_SLOTS);
    localparam int AW     = SLOT_W + 4;
    localparam int DEPTH  = 12 << SLOT_W;

    logic [AW-1:0] fill_reg;
    logic [AW-1:0] fill_next;
    logic          loaded_reg;
    logic          loaded_next;

    always_comb
    begin
        fill_next   = fill_reg;
        loaded_next = loaded_reg;
        if (!loaded_reg)
        begin
            fill_next = fill_reg + AW'(1);
            if (fill_reg == AW'(DEPTH - 1))
            begin
                loaded_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            loaded_reg <= loaded_next;
        end
    end

    assign we     = !loaded_reg;
    assign waddr  = fill_reg;
    assign wdata  = bps_pkg::table_step(fill_reg[AW-1:SLOT_W], 6'(fill_reg[SLOT_W-1:0]));
    assign loaded = loaded_reg;

endmodule

`default_nettype wire

FILE: src/bps_core.sv
// Playback state, step update against the prefetched table entry, and result register.
`default_nettype none

module bps_core #(
    parameter int STEP_SLOTS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         loaded,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire bps_pkg::req_t                req,
    output logic                              rsp_valid,
    input  wire logic                         rsp_ready,
    output bps_pkg::rsp_t                     rsp,
    output logic [$clog2(STEP_SLOTS)+3:0]     raddr,
    input  wire bps_pkg::step_t               rdata
);

    localparam int SLOT_W = $clog2(STEP_SLOTS);
    localparam int AW     = SLOT_W + 4;

    logic          active_reg,    active_next;
    logic [3:0]    pattern_reg,   pattern_next;
    logic [4:0]    step_reg,      step_next;
    logic [11:0]   count_reg,     count_next;
    logic          sounding_reg,  sounding_next;
    logic [12:0]   freq_reg,      freq_next;
    logic          rsp_valid_reg, rsp_valid_next;
    bps_pkg::rsp_t rsp_reg,       rsp_next;

    logic           accept;
    logic [11:0]    count_dec;
    logic           step_ok;
    logic           step_ok_next;
    bps_pkg::step_t cur;

    assign req_ready = loaded && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;

    // rdata holds the entry for (pattern_reg, step_reg), read last cycle.
    assign step_ok   = (pattern_reg < bps_pkg::PATTERN_COUNT) && (int'(step_reg) < STEP_SLOTS);
    assign cur       = step_ok ? rdata : bps_pkg::END_STEP;
    assign count_dec = (count_reg != 12'd0) ? (count_reg - 12'd1) : 12'd0;

    always_comb
    begin
        active_next   = active_reg;
        pattern_next  = pattern_reg;
        step_next     = step_reg;
        count_next    = count_reg;
        sounding_next = sounding_reg;
        freq_next     = freq_reg;
        if (accept)
        begin
            if (req.command == bps_pkg::CMD_START)
            begin
                pattern_next = req.sound_select;
                step_next    = 5'd0;
                count_next   = 12'd0;
                active_next  = 1'b1;
            end
            else if (active_reg)
            begin
                count_next = count_dec;
                if (count_dec == 12'd0)
                begin
                    unique case (cur.kind)
                        bps_pkg::STEP_TONE:
                        begin
                            sounding_next = 1'b1;
                            freq_next     = cur.hz;
                            count_next    = cur.ms;
                        end
                        bps_pkg::STEP_QUIET:
                        begin
                            sounding_next = 1'b0;
                            freq_next     = 13'd0;
                            count_next    = cur.ms;
                        end
                        default:
                        begin
                            active_next = 1'b0;
                            count_next  = 12'd0;
                        end
                    endcase
                    step_next = step_reg + 5'd1;
                end
            end
        end
    end

    // Prefetch the entry for the state being written.
    assign step_ok_next = (pattern_next < bps_pkg::PATTERN_COUNT)
                          && (int'(step_next) < STEP_SLOTS);
    assign raddr = step_ok_next ? ((AW'(pattern_next) << SLOT_W) | AW'(step_next)) : '0;

    always_comb
    begin
        rsp_next           = rsp_reg;
        rsp_valid_next     = rsp_valid_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.tone_on   = sounding_next;
            rsp_next.tone_freq = freq_next;
            rsp_next.playing   = active_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pattern_reg   <= 4'd0;
            step_reg      <= 5'd0;
            count_reg     <= 12'd0;
            sounding_reg  <= 1'b0;
            freq_reg      <= 13'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pattern_reg   <= pattern_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            sounding_reg  <= sounding_next;
            freq_reg      <= freq_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_start_plays: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.command == bps_pkg::CMD_START
        |=> rsp_valid_reg && rsp_reg.playing && step_reg == 5'd0 && count_reg == 12'd0)
        else $error("start word did not restart playback");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> count_reg == 12'd0)
        else $error("countdown running while idle");

    a_sound_freq: assert property (@(posedge clk) disable iff (!rst_n)
        sounding_reg == (freq_reg != 13'd0))
        else $error("tone state and frequency disagree");

    a_rsp_freq: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.tone_on || rsp_reg.tone_freq == 13'd0))
        else $error("silent result with nonzero frequency");
`endif

endmodule

`default_nettype wire

FILE: src/buzzer_pattern_sequencer.sv
// Top level of the buzzer pattern sequencer: step table loader, step RAM and playback core.
`default_nettype none

// Plays one of twelve beep patterns. Each word on req is either a one millisecond
// tick or a start of the pattern in sound_select; each gives exactly one word on rsp
// with the tone state, its frequency and whether a pattern is still playing. The
// step table lives in a RAM with registered read data; the entry for the current
// step is fetched in the cycle the state is updated, so a word is accepted every
// cycle while rsp_ready is high, and its result appears on rsp in the next cycle.
// After reset the whole table is copied into the RAM, and req_ready stays low
// until the copy is done.
module buzzer_pattern_sequencer #(
    parameter int STEP_SLOTS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire bps_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output bps_pkg::rsp_t      rsp
);

    localparam int SLOT_W = $clog2(STEP_SLOTS);
    localparam int AW     = SLOT_W + 4;
    localparam int DEPTH  = 12 << SLOT_W;

    logic           we;
    logic [AW-1:0]  waddr;
    bps_pkg::step_t wdata;
    logic [AW-1:0]  raddr;
    bps_pkg::step_t rdata;
    logic           loaded;

    bps_loader #(
        .STEP_SLOTS (STEP_SLOTS)
    ) u_loader (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .loaded (loaded)
    );

    bps_ram #(
        .WIDTH ($bits(bps_pkg::step_t)),
        .DEPTH (DEPTH)
    ) u_step_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    bps_core #(
        .STEP_SLOTS (STEP_SLOTS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .loaded    (loaded),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .raddr     (raddr),
        .rdata     (rdata)
    );

endmodule

`default_nettype wire
